FILE: design/hsme_pkg.sv
// ----------------------------------------------------------------------------
// hsme_pkg: shared types and constants
// Table entry layout, microcode control word, code points and the microcode
// ROM of the hierarchical state machine engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hsme_pkg;

    localparam int STATE_W     = 4;
    localparam int EVENT_W     = 4;
    localparam int MASK_W      = 16;
    localparam int STATE_SLOTS = 16;

    // commands (s_tuser)
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;
    localparam logic [1:0] CMD_TRANS = 2'd3;

    // result kinds (m_tuser)
    localparam logic [1:0] K_EXIT   = 2'd0;
    localparam logic [1:0] K_ENTER  = 2'd1;
    localparam logic [1:0] K_REPORT = 2'd2;
    localparam logic [1:0] K_STATUS = 2'd3;

    typedef struct packed {
        logic [STATE_W-1:0] parent;
        logic [STATE_W-1:0] init_child;
        logic               has_enter;
        logic               has_exit;
        logic [MASK_W-1:0]  mask;
    } entry_t;

    // branch conditions
    localparam int COND_W = 4;
    localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
    localparam logic [COND_W-1:0] C_NOT_VALID   = 4'd1;
    localparam logic [COND_W-1:0] C_TGT_IS_CUR  = 4'd2;
    localparam logic [COND_W-1:0] C_P_IS_CUR    = 4'd3;
    localparam logic [COND_W-1:0] C_AT_GOAL     = 4'd4;
    localparam logic [COND_W-1:0] C_CAP         = 4'd5;
    localparam logic [COND_W-1:0] C_INIT_ZERO   = 4'd6;
    localparam logic [COND_W-1:0] C_HIT         = 4'd7;
    localparam logic [COND_W-1:0] C_ZERO_OR_CAP = 4'd8;
    localparam logic [COND_W-1:0] C_BAD_FIND    = 4'd9;

    // result emitted by a step
    localparam int EMIT_W = 4;
    localparam logic [EMIT_W-1:0] EM_NONE       = 4'd0;
    localparam logic [EMIT_W-1:0] EM_EXIT       = 4'd1;
    localparam logic [EMIT_W-1:0] EM_ENTER      = 4'd2;
    localparam logic [EMIT_W-1:0] EM_STAT_CUR   = 4'd3;
    localparam logic [EMIT_W-1:0] EM_STAT_BAD   = 4'd4;
    localparam logic [EMIT_W-1:0] EM_STAT_S     = 4'd5;
    localparam logic [EMIT_W-1:0] EM_STAT_FAIL  = 4'd6;
    localparam logic [EMIT_W-1:0] EM_REP_S      = 4'd7;
    localparam logic [EMIT_W-1:0] EM_REP_NONE   = 4'd8;

    // walk pointer source
    localparam logic [2:0] S_KEEP   = 3'd0;
    localparam logic [2:0] S_PARENT = 3'd1;
    localparam logic [2:0] S_INIT   = 3'd2;
    localparam logic [2:0] S_ZERO   = 3'd3;
    localparam logic [2:0] S_CUR    = 3'd4;
    localparam logic [2:0] S_TGT    = 3'd5;

    // goal source
    localparam logic [1:0] G_KEEP = 2'd0;
    localparam logic [1:0] G_ZERO = 2'd1;
    localparam logic [1:0] G_TGT  = 2'd2;
    localparam logic [1:0] G_P    = 2'd3;

    // microcode addresses
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] A_LD     = 5'd0;
    localparam logic [UPC_W-1:0] A_RS0    = 5'd1;
    localparam logic [UPC_W-1:0] A_RSX    = 5'd2;
    localparam logic [UPC_W-1:0] A_RSE    = 5'd3;
    localparam logic [UPC_W-1:0] A_ENT    = 5'd4;
    localparam logic [UPC_W-1:0] A_FIN    = 5'd5;
    localparam logic [UPC_W-1:0] A_FAIL   = 5'd6;
    localparam logic [UPC_W-1:0] A_FH0    = 5'd7;
    localparam logic [UPC_W-1:0] A_FH1    = 5'd8;
    localparam logic [UPC_W-1:0] A_FHREP  = 5'd9;
    localparam logic [UPC_W-1:0] A_FHNONE = 5'd10;
    localparam logic [UPC_W-1:0] A_TR0    = 5'd11;
    localparam logic [UPC_W-1:0] A_TR1    = 5'd12;
    localparam logic [UPC_W-1:0] A_TA     = 5'd13;
    localparam logic [UPC_W-1:0] A_TAY    = 5'd14;
    localparam logic [UPC_W-1:0] A_TX1    = 5'd15;
    localparam logic [UPC_W-1:0] A_TAN    = 5'd16;
    localparam logic [UPC_W-1:0] A_TB     = 5'd17;
    localparam logic [UPC_W-1:0] A_TBY    = 5'd18;
    localparam logic [UPC_W-1:0] A_TX2    = 5'd19;
    localparam logic [UPC_W-1:0] A_TRE    = 5'd20;
    localparam logic [UPC_W-1:0] A_TRBAD  = 5'd21;
    localparam logic [UPC_W-1:0] A_LAST   = A_TRBAD;

    // cond_a wins, then cond_b; otherwise the step performs its actions
    // and moves to nxt (or finishes when done is set)
    typedef struct packed {
        logic [COND_W-1:0] cond_a;
        logic [UPC_W-1:0]  tgt_a;
        logic [COND_W-1:0] cond_b;
        logic [UPC_W-1:0]  tgt_b;
        logic              emit_on_b;
        logic [EMIT_W-1:0] emit;
        logic              rd_tgt;
        logic [2:0]        s_sel;
        logic              steps_clr;
        logic              steps_inc;
        logic [1:0]        goal_sel;
        logic              p_load;
        logic [UPC_W-1:0]  nxt;
        logic              done;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_word_t w;
        w = '0;
        unique case (addr)
            A_LD: begin
                w.emit = EM_STAT_CUR; w.done = 1'b1;
            end
            A_RS0: begin
                w.cond_a = C_NOT_VALID; w.tgt_a = A_RSE;
                w.goal_sel = G_ZERO; w.nxt = A_RSX;
            end
            A_RSX: begin
                w.cond_a = C_AT_GOAL; w.tgt_a = A_RSE;
                w.cond_b = C_CAP; w.tgt_b = A_FAIL;
                w.emit = EM_EXIT; w.s_sel = S_PARENT; w.steps_inc = 1'b1;
                w.nxt = A_RSX;
            end
            A_RSE: begin
                w.s_sel = S_ZERO; w.steps_clr = 1'b1; w.nxt = A_ENT;
            end
            A_ENT: begin
                // the enter notice goes out also on the step that ends the chain
                w.cond_a = C_CAP; w.tgt_a = A_FAIL;
                w.cond_b = C_INIT_ZERO; w.tgt_b = A_FIN; w.emit_on_b = 1'b1;
                w.emit = EM_ENTER; w.s_sel = S_INIT; w.steps_inc = 1'b1;
                w.nxt = A_ENT;
            end
            A_FIN: begin
                w.emit = EM_STAT_S; w.done = 1'b1;
            end
            A_FAIL: begin
                w.emit = EM_STAT_FAIL; w.done = 1'b1;
            end
            A_FH0: begin
                w.cond_a = C_BAD_FIND; w.tgt_a = A_FHNONE; w.nxt = A_FH1;
            end
            A_FH1: begin
                w.cond_a = C_HIT; w.tgt_a = A_FHREP;
                w.cond_b = C_ZERO_OR_CAP; w.tgt_b = A_FHNONE;
                w.s_sel = S_PARENT; w.steps_inc = 1'b1; w.nxt = A_FH1;
            end
            A_FHREP: begin
                w.emit = EM_REP_S; w.done = 1'b1;
            end
            A_FHNONE: begin
                w.emit = EM_REP_NONE; w.done = 1'b1;
            end
            A_TR0: begin
                w.rd_tgt = 1'b1;
                w.cond_a = C_NOT_VALID; w.tgt_a = A_TRBAD;
                w.cond_b = C_TGT_IS_CUR; w.tgt_b = A_LD;
                w.p_load = 1'b1; w.goal_sel = G_TGT; w.nxt = A_TR1;
            end
            A_TR1: begin
                w.cond_a = C_P_IS_CUR; w.tgt_a = A_TRE; w.nxt = A_TA;
            end
            A_TA: begin
                w.cond_a = C_AT_GOAL; w.tgt_a = A_TAY;
                w.cond_b = C_ZERO_OR_CAP; w.tgt_b = A_TAN;
                w.s_sel = S_PARENT; w.steps_inc = 1'b1; w.nxt = A_TA;
            end
            A_TAY: begin
                w.s_sel = S_CUR; w.steps_clr = 1'b1; w.nxt = A_TX1;
            end
            A_TX1: begin
                w.cond_a = C_AT_GOAL; w.tgt_a = A_FIN;
                w.cond_b = C_CAP; w.tgt_b = A_FAIL;
                w.emit = EM_EXIT; w.s_sel = S_PARENT; w.steps_inc = 1'b1;
                w.nxt = A_TX1;
            end
            A_TAN: begin
                w.goal_sel = G_P; w.s_sel = S_CUR; w.steps_clr = 1'b1;
                w.nxt = A_TB;
            end
            A_TB: begin
                w.cond_a = C_AT_GOAL; w.tgt_a = A_TBY;
                w.cond_b = C_ZERO_OR_CAP; w.tgt_b = A_FAIL;
                w.s_sel = S_PARENT; w.steps_inc = 1'b1; w.nxt = A_TB;
            end
            A_TBY: begin
                w.s_sel = S_CUR; w.steps_clr = 1'b1; w.nxt = A_TX2;
            end
            A_TX2: begin
                w.cond_a = C_AT_GOAL; w.tgt_a = A_TRE;
                w.cond_b = C_CAP; w.tgt_b = A_FAIL;
                w.emit = EM_EXIT; w.s_sel = S_PARENT; w.steps_inc = 1'b1;
                w.nxt = A_TX2;
            end
            A_TRE: begin
                w.s_sel = S_TGT; w.steps_clr = 1'b1; w.nxt = A_ENT;
            end
            A_TRBAD: begin
                w.emit = EM_STAT_BAD; w.done = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/hsme_state_table.sv
// ----------------------------------------------------------------------------
// hsme_state_table: state description table
// One write port for entry loads and one combinational read port; indexes
// at or beyond NUM_STATES are dropped on write and read back as zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module hsme_state_table
    import hsme_pkg::*;
#(
    parameter int NUM_STATES = 16
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [STATE_W-1:0] wr_addr,
    input  wire entry_t             wr_entry,
    input  wire logic [STATE_W-1:0] rd_addr,
    output entry_t                  rd_entry
);

    localparam int ST_LIMIT = (NUM_STATES < STATE_SLOTS) ? NUM_STATES : STATE_SLOTS;
    localparam logic [STATE_W:0] ST_LIM = (STATE_W + 1)'(ST_LIMIT);

    entry_t mem [STATE_SLOTS];

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = {1'b0, wr_addr} < ST_LIM;
    assign rd_in_range = {1'b0, rd_addr} < ST_LIM;

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    assign rd_entry = rd_in_range ? mem[rd_addr] : '0;

endmodule

`default_nettype wire

FILE: design/hierarchical_state_machine_engine.sv
// ----------------------------------------------------------------------------
// hierarchical_state_machine_engine: statechart walker
// Microcoded sequencer over a state table: load, reset, find handler and
// transition commands produce exit/enter notices and a closing result.
// ----------------------------------------------------------------------------
// Each exit, enter or find level costs one sequencer step (one table read); a
// transition adds up to two ancestor walks (one step per level) plus up to 6
// fixed steps. Commands are taken one at a time: s_tready stays low while a
// command runs. Reset: sequencer and output valid cleared; state 0, valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_state_machine_engine
    import hsme_pkg::*;
#(
    parameter int NUM_STATES = 16,
    parameter int NUM_EVENTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] target_state, [7:4] event_code, [11:8] parent_state,
    // [15:12] initial_child, [16] has_enter, [17] has_exit,
    // [33:18] handled_mask, [39:34] zero
    input  wire logic [39:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] state_out, [4] ok, [7:5] zero
    output logic [7:0]       m_tdata,
    // [1:0] kind
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int STEP_W = $clog2(NUM_STATES + 1);
    localparam logic [STEP_W-1:0] CAP_VAL = STEP_W'(NUM_STATES);
    localparam int EV_LIMIT = (NUM_EVENTS < MASK_W) ? NUM_EVENTS : MASK_W;
    localparam logic [EVENT_W:0] EV_LIM = (EVENT_W + 1)'(EV_LIMIT);

    // control
    logic               busy_reg,  busy_next;
    logic [UPC_W-1:0]   upc_reg,   upc_next;
    logic [STATE_W-1:0] cur_reg,   cur_next;
    logic               valid_reg, valid_next;
    logic               mvalid_reg, mvalid_next;

    // datapath
    logic [STATE_W-1:0] s_reg,    s_next;
    logic [STATE_W-1:0] goal_reg, goal_next;
    logic [STATE_W-1:0] p_reg,    p_next;
    logic [STATE_W-1:0] tgt_reg,  tgt_next;
    logic [EVENT_W-1:0] ev_reg,   ev_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [1:0]         kind_reg, kind_next;
    logic [STATE_W-1:0] sout_reg, sout_next;
    logic               ok_reg,   ok_next;
    logic               last_reg, last_next;

    ctrl_word_t         cw;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic [STATE_W-1:0] rd_addr;
    logic               s_accept;
    logic               ev_ok;
    logic [15:0]        condv;
    logic               take_a;
    logic               take_b;
    logic               act;
    logic               stall;
    logic               step;
    logic               emit_gate;
    logic               do_emit;
    logic [UPC_W-1:0]   entry_upc;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && !busy_reg;

    assign wr_entry.parent     = s_tdata[11:8];
    assign wr_entry.init_child = s_tdata[15:12];
    assign wr_entry.has_enter  = s_tdata[16];
    assign wr_entry.has_exit   = s_tdata[17];
    assign wr_entry.mask       = s_tdata[33:18];

    assign cw      = ucode_rom(upc_reg);
    assign rd_addr = cw.rd_tgt ? tgt_reg : s_reg;

    hsme_state_table #(
        .NUM_STATES(NUM_STATES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (s_accept && (s_tuser == CMD_LOAD)),
        .wr_addr (s_tdata[3:0]),
        .wr_entry(wr_entry),
        .rd_addr (rd_addr),
        .rd_entry(rd_entry)
    );

    assign ev_ok = {1'b0, ev_reg} < EV_LIM;

    always_comb begin
        condv                = '0;
        condv[C_NOT_VALID]   = !valid_reg;
        condv[C_TGT_IS_CUR]  = tgt_reg == cur_reg;
        condv[C_P_IS_CUR]    = p_reg == cur_reg;
        condv[C_AT_GOAL]     = s_reg == goal_reg;
        condv[C_CAP]         = steps_reg >= CAP_VAL;
        condv[C_INIT_ZERO]   = rd_entry.init_child == '0;
        condv[C_HIT]         = ev_ok && rd_entry.mask[ev_reg];
        condv[C_ZERO_OR_CAP] = (s_reg == '0) || (steps_reg >= CAP_VAL);
        condv[C_BAD_FIND]    = !valid_reg || !ev_ok;
    end

    assign take_a = condv[cw.cond_a];
    assign take_b = !take_a && condv[cw.cond_b];
    assign act    = !take_a && !take_b;

    // any step that may emit waits for a free output register
    assign stall = (cw.emit != EM_NONE) && mvalid_reg && !m_tready;
    assign step  = busy_reg && !stall;

    always_comb begin
        case (cw.emit)
            EM_NONE:  emit_gate = 1'b0;
            EM_EXIT:  emit_gate = rd_entry.has_exit;
            EM_ENTER: emit_gate = rd_entry.has_enter;
            default:  emit_gate = 1'b1;
        endcase
    end

    assign do_emit = step && emit_gate && (act || (take_b && cw.emit_on_b));

    always_comb begin
        unique case (s_tuser)
            CMD_LOAD:  entry_upc = A_LD;
            CMD_RESET: entry_upc = A_RS0;
            CMD_FIND:  entry_upc = A_FH0;
            CMD_TRANS: entry_upc = A_TR0;
            default:   entry_upc = A_LD;
        endcase
    end

    always_comb begin
        busy_next   = busy_reg;
        upc_next    = upc_reg;
        cur_next    = cur_reg;
        valid_next  = valid_reg;
        mvalid_next = mvalid_reg && !m_tready;
        s_next      = s_reg;
        goal_next   = goal_reg;
        p_next      = p_reg;
        tgt_next    = tgt_reg;
        ev_next     = ev_reg;
        steps_next  = steps_reg;
        kind_next   = kind_reg;
        sout_next   = sout_reg;
        ok_next     = ok_reg;
        last_next   = last_reg;

        if (s_accept) begin
            busy_next  = 1'b1;
            upc_next   = entry_upc;
            s_next     = cur_reg;
            steps_next = '0;
            tgt_next   = s_tdata[3:0];
            ev_next    = s_tdata[7:4];
        end

        if (step) begin
            if (take_a) begin
                upc_next = cw.tgt_a;
            end else if (take_b) begin
                upc_next = cw.tgt_b;
            end else begin
                unique case (cw.s_sel)
                    S_KEEP:   s_next = s_reg;
                    S_PARENT: s_next = rd_entry.parent;
                    S_INIT:   s_next = rd_entry.init_child;
                    S_ZERO:   s_next = '0;
                    S_CUR:    s_next = cur_reg;
                    S_TGT:    s_next = tgt_reg;
                    default:  s_next = s_reg;
                endcase
                unique case (cw.goal_sel)
                    G_KEEP:  goal_next = goal_reg;
                    G_ZERO:  goal_next = '0;
                    G_TGT:   goal_next = tgt_reg;
                    G_P:     goal_next = p_reg;
                    default: goal_next = goal_reg;
                endcase
                if (cw.steps_clr) begin
                    steps_next = '0;
                end else if (cw.steps_inc) begin
                    steps_next = steps_reg + 1'b1;
                end
                if (cw.p_load) begin
                    p_next = rd_entry.parent;
                end
                if (cw.done) begin
                    busy_next = 1'b0;
                end else begin
                    upc_next = cw.nxt;
                end
            end
        end

        if (do_emit) begin
            mvalid_next = 1'b1;
            unique case (cw.emit)
                EM_EXIT: begin
                    kind_next = K_EXIT;   sout_next = s_reg;   ok_next = 1'b1;
                    last_next = 1'b0;
                end
                EM_ENTER: begin
                    kind_next = K_ENTER;  sout_next = s_reg;   ok_next = 1'b1;
                    last_next = 1'b0;
                end
                EM_STAT_CUR: begin
                    kind_next = K_STATUS; sout_next = cur_reg; ok_next = 1'b1;
                    last_next = 1'b1;
                end
                EM_STAT_BAD: begin
                    kind_next = K_STATUS; sout_next = cur_reg; ok_next = 1'b0;
                    last_next = 1'b1;
                end
                EM_STAT_S: begin
                    kind_next = K_STATUS; sout_next = s_reg;   ok_next = 1'b1;
                    last_next = 1'b1;
                    cur_next  = s_reg;
                    valid_next = 1'b1;
                end
                EM_STAT_FAIL: begin
                    kind_next = K_STATUS; sout_next = '0;      ok_next = 1'b0;
                    last_next = 1'b1;
                    cur_next  = '0;
                    valid_next = 1'b0;
                end
                EM_REP_S: begin
                    kind_next = K_REPORT; sout_next = s_reg;   ok_next = 1'b1;
                    last_next = 1'b1;
                end
                default: begin
                    kind_next = K_REPORT; sout_next = '0;      ok_next = 1'b0;
                    last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            upc_reg    <= A_LD;
            cur_reg    <= '0;
            valid_reg  <= 1'b1;
            mvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            upc_reg    <= upc_next;
            cur_reg    <= cur_next;
            valid_reg  <= valid_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg     <= s_next;
        goal_reg  <= goal_next;
        p_reg     <= p_next;
        tgt_reg   <= tgt_next;
        ev_reg    <= ev_next;
        steps_reg <= steps_next;
        kind_reg  <= kind_next;
        sout_reg  <= sout_next;
        ok_reg    <= ok_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {3'b000, ok_reg, sout_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // reset leaves a valid root state
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (valid_reg && (cur_reg == '0)))
        else $error("current state not restored by reset");

    // an invalid machine always parks at state 0
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> (cur_reg == '0))
        else $error("invalid state with nonzero current state");

    // finishing a command leaves its closing transfer in the output register
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(busy_reg) && $past(aresetn)) |-> (mvalid_reg && last_reg))
        else $error("command finished without a closing transfer");

    // sequencer stays inside the program
    a_upc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (upc_reg <= A_LAST))
        else $error("microcode address out of range");

endmodule

`default_nettype wire

FILE: sim/tb_hierarchical_state_machine_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hierarchical_state_machine_engine: self-checking bench for the statechart walker
// Loads state tables, then issues reset, find-handler and transition commands.
// A local copy of the state table predicts every exit/enter notice and the
// closing result; results are checked in order, field by field, under random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_hierarchical_state_machine_engine;
    import hsme_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 480;
    localparam int MAX_GAP      = 18;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_WAIT  = 200;
    localparam int CYCLE_LIMIT  = 1_500_000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [STATE_W-1:0] tgt;
        logic [EVENT_W-1:0] ev;
        entry_t             ent;
        logic               drain;  // hold off until all results are back
    } order_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [STATE_W-1:0] st;
        logic               ok;
        logic               last;
    } notice_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    order_t  pend_q[$];
    notice_t expected_q[$];

    // predicted engine state
    entry_t             chart [STATE_SLOTS];
    logic [STATE_W-1:0] cur_state = '0;
    logic               cur_valid = 1'b1;

    logic        in_xfer   = 1'b0;
    logic        out_xfer  = 1'b0;
    order_t      tx_cur;
    logic        tx_armed  = 1'b0;
    logic        tx_calm   = 1'b0;
    int          tx_wait   = 0;
    logic        rx_calm   = 1'b0;
    int          rx_wait   = 0;
    int          fault_cnt = 0;
    int unsigned cycle_cnt = 0;

    hierarchical_state_machine_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic void push_notice(logic [1:0] kind, logic [STATE_W-1:0] st,
                                        logic ok, logic last);
        notice_t n;
        n.kind = kind;
        n.st   = st;
        n.ok   = ok;
        n.last = last;
        expected_q.push_back(n);
    endfunction

    function automatic void settle(logic good, logic [STATE_W-1:0] st);
        cur_valid = good;
        cur_state = good ? st : '0;
        push_notice(K_STATUS, cur_state, good, 1'b1);
    endfunction

    // exit from 'from' up to, not including, 'goal'; 0 when the step cap is hit
    function automatic logic climb_out(logic [STATE_W-1:0] from, logic [STATE_W-1:0] goal);
        logic [STATE_W-1:0] s;
        int steps;
        s = from;
        steps = 0;
        while (s != goal) begin
            if (steps >= STATE_SLOTS)
                return 1'b0;
            if (chart[s].has_exit)
                push_notice(K_EXIT, s, 1'b1, 1'b0);
            s = chart[s].parent;
            steps++;
        end
        return 1'b1;
    endfunction

    // enter 'start' and follow the initial-child chain
    function automatic logic descend(logic [STATE_W-1:0] start,
                                     output logic [STATE_W-1:0] landed);
        logic [STATE_W-1:0] s;
        int k;
        s = start;
        for (k = 0; k < STATE_SLOTS; k++) begin
            if (chart[s].has_enter)
                push_notice(K_ENTER, s, 1'b1, 1'b0);
            if (chart[s].init_child == '0) begin
                landed = s;
                return 1'b1;
            end
            s = chart[s].init_child;
        end
        landed = s;
        return 1'b0;
    endfunction

    // goal reached walking up from s (s itself included)
    function automatic logic lies_above(logic [STATE_W-1:0] goal, logic [STATE_W-1:0] s);
        int steps;
        steps = 0;
        while (s != goal) begin
            if (s == '0 || steps >= STATE_SLOTS)
                return 1'b0;
            s = chart[s].parent;
            steps++;
        end
        return 1'b1;
    endfunction

    function automatic void predict_notices(order_t o);
        logic [STATE_W-1:0] s, landed, p;
        logic good, hit, stop;
        int k;
        case (o.cmd)
            CMD_LOAD: begin
                chart[o.tgt] = o.ent;
                push_notice(K_STATUS, cur_state, 1'b1, 1'b1);
            end
            CMD_RESET: begin
                if (cur_valid && !climb_out(cur_state, '0)) begin
                    settle(1'b0, '0);
                end else begin
                    good = descend('0, landed);
                    settle(good, landed);
                end
            end
            CMD_FIND: begin
                hit  = 1'b0;
                stop = !cur_valid;
                s    = cur_state;
                // root is checked last; the walk is capped one past the table size
                for (k = 0; k <= STATE_SLOTS; k++) begin
                    if (!stop) begin
                        if (chart[s].mask[o.ev]) begin
                            hit  = 1'b1;
                            stop = 1'b1;
                        end else if (s == '0) begin
                            stop = 1'b1;
                        end else begin
                            s = chart[s].parent;
                        end
                    end
                end
                if (hit)
                    push_notice(K_REPORT, s, 1'b1, 1'b1);
                else
                    push_notice(K_REPORT, '0, 1'b0, 1'b1);
            end
            CMD_TRANS: begin
                p = chart[o.tgt].parent;
                if (!cur_valid || o.tgt == cur_state) begin
                    push_notice(K_STATUS, cur_state, cur_valid, 1'b1);
                end else if (p == cur_state) begin
                    good = descend(o.tgt, landed);
                    settle(good, landed);
                end else if (lies_above(o.tgt, cur_state)) begin
                    good = climb_out(cur_state, o.tgt);
                    settle(good, o.tgt);
                end else if (lies_above(p, cur_state) && climb_out(cur_state, p)) begin
                    good = descend(o.tgt, landed);
                    settle(good, landed);
                end else begin
                    settle(1'b0, '0);
                end
            end
        endcase
    endfunction

    function automatic void queue_order(logic [1:0] cmd, logic [STATE_W-1:0] tgt,
                                        logic [EVENT_W-1:0] ev, logic [STATE_W-1:0] par,
                                        logic [STATE_W-1:0] ini, logic en, logic ex,
                                        logic [MASK_W-1:0] mask, logic drain);
        order_t o;
        o.cmd            = cmd;
        o.tgt            = tgt;
        o.ev             = ev;
        o.ent.parent     = par;
        o.ent.init_child = ini;
        o.ent.has_enter  = en;
        o.ent.has_exit   = ex;
        o.ent.mask       = mask;
        o.drain          = drain;
        pend_q.push_back(o);
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return MASK_W'($urandom);
            default: return MASK_W'($urandom & $urandom & $urandom);
        endcase
    endfunction

    // sender
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_xfer)) begin
            if (!tx_armed && pend_q.size() != 0 &&
                (!pend_q[0].drain || expected_q.size() == 0)) begin
                tx_cur   = pend_q.pop_front();
                tx_armed = 1'b1;
                if ($urandom_range(0, 11) == 0)
                    tx_calm = !tx_calm;
                tx_wait = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (tx_armed && tx_wait == 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= tx_cur.cmd;
                s_tdata  <= {6'b0, tx_cur.ent.mask, tx_cur.ent.has_exit,
                             tx_cur.ent.has_enter, tx_cur.ent.init_child,
                             tx_cur.ent.parent, tx_cur.ev, tx_cur.tgt};
                tx_armed = 1'b0;
            end else begin
                s_tvalid <= 1'b0;
                if (tx_armed)
                    tx_wait--;
            end
        end
    end

    // receiver: a fresh stall is drawn after every result transfer
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_xfer) begin
                if ($urandom_range(0, 11) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (rx_wait != 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        order_t  seen;
        notice_t got, want;
        in_xfer  <= s_tvalid && s_tready;
        out_xfer <= m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            seen.cmd            = s_tuser;
            seen.tgt            = s_tdata[3:0];
            seen.ev             = s_tdata[7:4];
            seen.ent.parent     = s_tdata[11:8];
            seen.ent.init_child = s_tdata[15:12];
            seen.ent.has_enter  = s_tdata[16];
            seen.ent.has_exit   = s_tdata[17];
            seen.ent.mask       = s_tdata[33:18];
            seen.drain          = 1'b0;
            predict_notices(seen);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.st   = m_tdata[3:0];
            got.ok   = m_tdata[4];
            got.last = m_tlast;
            if (expected_q.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result kind %0d state %0d ok %0b last %0b",
                             $time, got.kind, got.st, got.ok, got.last);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    fault_cnt++;
                    if (fault_cnt <= MAX_REPORTS) begin
                        $write("%0t: mismatch, expected kind %0d state %0d ok %0b last %0b,",
                               $time, want.kind, want.st, want.ok, want.last);
                        $display(" got kind %0d state %0d ok %0b last %0b",
                                 got.kind, got.st, got.ok, got.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        logic [STATE_W-1:0] par  [STATE_SLOTS];
        logic [STATE_W-1:0] ini  [STATE_SLOTS];
        logic [STATE_W-1:0] kids [STATE_SLOTS];
        logic               deep;
        int                 n_made, ops, r, s, c, nk, k;

        // directed table: 0-1-2 and 1-3-4-8 branches, 5-6-7 with an initial-child
        // loop, 9-10 whose initial chain lands in the 10/11 parent loop
        queue_order(CMD_LOAD, 4'd0,  4'd0, 4'd0,  4'd1,  1'b1, 1'b1, 16'h0001, 1'b0);
        queue_order(CMD_LOAD, 4'd1,  4'd0, 4'd0,  4'd2,  1'b1, 1'b1, 16'h0002, 1'b0);
        queue_order(CMD_LOAD, 4'd2,  4'd0, 4'd1,  4'd0,  1'b1, 1'b1, 16'h8000, 1'b0);
        queue_order(CMD_LOAD, 4'd3,  4'd0, 4'd1,  4'd4,  1'b1, 1'b0, 16'h0000, 1'b0);
        queue_order(CMD_LOAD, 4'd4,  4'd0, 4'd3,  4'd0,  1'b0, 1'b1, 16'hFFFF, 1'b0);
        queue_order(CMD_LOAD, 4'd5,  4'd0, 4'd0,  4'd0,  1'b0, 1'b0, 16'h0010, 1'b0);
        queue_order(CMD_LOAD, 4'd6,  4'd0, 4'd5,  4'd7,  1'b1, 1'b1, 16'h0000, 1'b0);
        queue_order(CMD_LOAD, 4'd7,  4'd0, 4'd6,  4'd6,  1'b1, 1'b1, 16'h0000, 1'b0);
        queue_order(CMD_LOAD, 4'd8,  4'd0, 4'd4,  4'd0,  1'b1, 1'b1, 16'h0100, 1'b0);
        queue_order(CMD_LOAD, 4'd9,  4'd0, 4'd0,  4'd10, 1'b1, 1'b1, 16'h0000, 1'b0);
        queue_order(CMD_LOAD, 4'd10, 4'd0, 4'd11, 4'd0,  1'b1, 1'b1, 16'h0400, 1'b0);
        queue_order(CMD_LOAD, 4'd11, 4'd0, 4'd10, 4'd0,  1'b0, 1'b1, 16'h0000, 1'b0);
        queue_order(CMD_RESET, 4'd0, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);
        queue_order(CMD_FIND,  4'd0, 4'd15, 4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);
        queue_order(CMD_FIND,  4'd0, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);
        queue_order(CMD_FIND,  4'd0, 4'd9,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // no handler
        queue_order(CMD_TRANS, 4'd2, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // to itself
        queue_order(CMD_TRANS, 4'd3, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // sibling
        queue_order(CMD_TRANS, 4'd8, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // child
        queue_order(CMD_TRANS, 4'd1, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // ancestor
        queue_order(CMD_TRANS, 4'd6, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // unrelated
        queue_order(CMD_FIND,  4'd0, 4'd4,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // while invalid
        queue_order(CMD_TRANS, 4'd5, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // while invalid
        queue_order(CMD_RESET, 4'd0, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);
        queue_order(CMD_TRANS, 4'd5, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);
        queue_order(CMD_TRANS, 4'd6, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // enter cap
        queue_order(CMD_RESET, 4'd0, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);
        queue_order(CMD_TRANS, 4'd9, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);
        queue_order(CMD_RESET, 4'd0, 4'd0,  4'd0, 4'd0, 1'b0, 1'b0, '0, 1'b0);  // exit cap

        // random rounds: a full fresh table, a reset, then mixed commands
        n_made = 0;
        while (n_made < RANDOM_ITEMS) begin
            deep = ($urandom_range(0, 3) == 0);
            for (s = 0; s < STATE_SLOTS; s++) begin
                if (s == 0)
                    par[s] = ($urandom_range(0, 3) == 0) ?
                             STATE_W'($urandom_range(0, 15)) : '0;
                else
                    par[s] = deep ? STATE_W'(s - 1) : STATE_W'($urandom_range(0, s - 1));
                if ($urandom_range(0, 15) == 0)
                    par[s] = STATE_W'($urandom_range(0, 15));  // may close a parent loop
            end
            for (s = 0; s < STATE_SLOTS; s++) begin
                nk = 0;
                for (c = s + 1; c < STATE_SLOTS; c++) begin
                    if (par[c] == STATE_W'(s)) begin
                        kids[nk] = STATE_W'(c);
                        nk++;
                    end
                end
                ini[s] = (nk != 0 && (deep || $urandom_range(0, 3) != 0)) ?
                         kids[$urandom_range(0, nk - 1)] : '0;
                if ($urandom_range(0, 15) == 0)
                    ini[s] = STATE_W'($urandom_range(0, 15));
                queue_order(CMD_LOAD, STATE_W'(s), EVENT_W'($urandom_range(0, 15)),
                            par[s], ini[s],
                            $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                            pick_mask(), s == 0);
            end
            queue_order(CMD_RESET, STATE_W'($urandom_range(0, 15)),
                        EVENT_W'($urandom_range(0, 15)),
                        STATE_W'($urandom_range(0, 15)), STATE_W'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        MASK_W'($urandom), 1'b0);
            ops = $urandom_range(40, 90);
            for (k = 0; k < ops; k++) begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    queue_order(CMD_LOAD, STATE_W'($urandom_range(0, 15)),
                                EVENT_W'($urandom_range(0, 15)),
                                STATE_W'($urandom_range(0, 15)),
                                STATE_W'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                pick_mask(), 1'b0);
                else
                    queue_order(r < 27 ? CMD_RESET : (r < 55 ? CMD_FIND : CMD_TRANS),
                                STATE_W'($urandom_range(0, 15)),
                                EVENT_W'($urandom_range(0, 15)),
                                STATE_W'($urandom_range(0, 15)),
                                STATE_W'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                MASK_W'($urandom), 1'b0);
            end
            n_made += STATE_SLOTS + 1 + ops;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() != 0)
            @(posedge aclk);
        while (tx_armed || s_tvalid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);

        if (fault_cnt == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
design/hsme_pkg.sv
design/hsme_state_table.sv
design/hierarchical_state_machine_engine.sv
sim/tb_hierarchical_state_machine_engine.sv
